FILE: sv/ps2ev_pkg.sv
// Shared types, codes and the extended-scancode table for the PS/2 event decoder.
`default_nettype none
package ps2ev_pkg;

    // event types
    localparam logic [1:0] EVT_SYNC = 2'd0;
    localparam logic [1:0] EVT_KEY  = 2'd1;
    localparam logic [1:0] EVT_REL  = 2'd2;

    // event codes
    localparam logic [8:0] CODE_SYNC   = 9'h000;
    localparam logic [8:0] CODE_REL_X  = 9'h000;
    localparam logic [8:0] CODE_REL_Y  = 9'h001;
    localparam logic [8:0] CODE_BTN_L  = 9'h110;
    localparam logic [8:0] CODE_BTN_R  = 9'h111;
    localparam logic [8:0] CODE_BTN_M  = 9'h112;

    localparam logic [7:0] KBD_EXT_PREFIX = 8'hE0;
    localparam logic signed [9:0] MOTION_SAT = 10'sd255;

    // bit positions in the per-report event mask, emitted lowest first
    localparam int unsigned EV_NUM = 7;
    localparam logic [2:0] EVB_X     = 3'd0;
    localparam logic [2:0] EVB_Y     = 3'd1;
    localparam logic [2:0] EVB_BTN_L = 3'd2;
    localparam logic [2:0] EVB_BTN_R = 3'd3;
    localparam logic [2:0] EVB_BTN_M = 3'd4;
    localparam logic [2:0] EVB_KEY   = 3'd5;
    localparam logic [2:0] EVB_SYNC  = 3'd6;

    // one decoded report, handed from front to back
    typedef struct packed {
        logic [EV_NUM-1:0]  events;
        logic [6:0]         key_code;
        logic               key_press;
        logic signed [9:0]  dx;
        logic signed [9:0]  dy;
        logic [2:0]         btn_new;
    } desc_t;

    function automatic logic [6:0] remap_ext(input logic [6:0] code);
        logic [6:0] res;
        case (code)
            7'h1C: res = 7'd96;
            7'h1D: res = 7'd97;
            7'h35: res = 7'd98;
            7'h38: res = 7'd100;
            7'h47: res = 7'd102;
            7'h48: res = 7'd103;
            7'h49: res = 7'd104;
            7'h4B: res = 7'd105;
            7'h4D: res = 7'd106;
            7'h4F: res = 7'd107;
            7'h50: res = 7'd108;
            7'h51: res = 7'd109;
            7'h52: res = 7'd110;
            7'h53: res = 7'd111;
            default: res = code;
        endcase
        return res;
    endfunction

endpackage
`default_nettype wire

FILE: sv/ps2ev_front.sv
// Front end: takes bytes, tracks prefix and packet framing, builds report descriptors.
`default_nettype none
module ps2ev_front (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             cfg_wr_en,
    input  wire logic             cfg_wr_data,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire logic [7:0]       s_data_byte,
    input  wire logic             s_from_aux_port,
    output logic                  push,
    output ps2ev_pkg::desc_t      push_desc,
    input  wire logic             full
);
    import ps2ev_pkg::*;

    logic       mouse_en_reg, mouse_en_next;
    logic       ext_reg, ext_next;
    logic [1:0] pos_reg, pos_next;
    logic [2:0] btn_reg, btn_next;
    logic [7:0] pkt0_reg, pkt0_next;
    logic [7:0] pkt1_reg, pkt1_next;

    logic              accept;
    logic              is_prefix;
    logic              kbd_word;
    logic              mouse_take;
    logic              pkt_done;
    logic signed [9:0] dx;
    logic signed [9:0] ry;
    logic signed [9:0] dy;
    logic [2:0]        chg;

    assign s_ready = !full;
    assign accept  = s_valid && s_ready;

    assign is_prefix  = (s_data_byte == KBD_EXT_PREFIX);
    assign kbd_word   = !s_from_aux_port && !is_prefix;
    assign mouse_take = s_from_aux_port && mouse_en_reg;
    assign pkt_done   = mouse_take && (pos_reg == 2'd2);

    // 9-bit motion with sign from the flag byte; overflow saturates
    always_comb begin
        ry = {pkt0_reg[5], pkt0_reg[5], s_data_byte};
        if (pkt0_reg[6]) begin
            dx = pkt0_reg[4] ? -MOTION_SAT : MOTION_SAT;
        end else begin
            dx = {pkt0_reg[4], pkt0_reg[4], pkt1_reg};
        end
        if (pkt0_reg[7]) begin
            dy = pkt0_reg[5] ? MOTION_SAT : -MOTION_SAT;
        end else begin
            dy = -ry;
        end
    end

    assign chg = pkt0_reg[2:0] ^ btn_reg;

    always_comb begin
        push_desc           = '0;
        push_desc.key_code  = ext_reg ? remap_ext(s_data_byte[6:0]) : s_data_byte[6:0];
        push_desc.key_press = !s_data_byte[7];
        push_desc.dx        = dx;
        push_desc.dy        = dy;
        push_desc.btn_new   = pkt0_reg[2:0];
        if (s_from_aux_port) begin
            push_desc.events[EVB_X]     = (dx != '0);
            push_desc.events[EVB_Y]     = (dy != '0);
            push_desc.events[EVB_BTN_L] = chg[0];
            push_desc.events[EVB_BTN_R] = chg[1];
            push_desc.events[EVB_BTN_M] = chg[2];
        end else begin
            push_desc.events[EVB_KEY]   = 1'b1;
        end
        push_desc.events[EVB_SYNC] = 1'b1;
    end

    assign push = accept && (kbd_word || pkt_done);

    always_comb begin
        mouse_en_next = cfg_wr_en ? cfg_wr_data : mouse_en_reg;
        ext_next      = ext_reg;
        pos_next      = pos_reg;
        btn_next      = btn_reg;
        pkt0_next     = pkt0_reg;
        pkt1_next     = pkt1_reg;
        if (accept) begin
            if (!s_from_aux_port) begin
                ext_next = is_prefix;
            end else if (mouse_take) begin
                if (pos_reg == 2'd0) begin
                    // unsynchronized flag byte is dropped
                    if (s_data_byte[3]) begin
                        pkt0_next = s_data_byte;
                        pos_next  = 2'd1;
                    end
                end else if (pos_reg == 2'd1) begin
                    pkt1_next = s_data_byte;
                    pos_next  = 2'd2;
                end else begin
                    pos_next = 2'd0;
                    btn_next = pkt0_reg[2:0];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mouse_en_reg <= 1'b0;
            ext_reg      <= 1'b0;
            pos_reg      <= 2'd0;
            btn_reg      <= 3'd0;
        end else begin
            mouse_en_reg <= mouse_en_next;
            ext_reg      <= ext_next;
            pos_reg      <= pos_next;
            btn_reg      <= btn_next;
        end
        pkt0_reg <= pkt0_next;
        pkt1_reg <= pkt1_next;
    end

endmodule
`default_nettype wire

FILE: sv/ps2ev_fifo.sv
// Small register-file queue of report descriptors between front and back.
`default_nettype none
module ps2ev_fifo #(
    parameter int unsigned DEPTH = 4
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  wire ps2ev_pkg::desc_t push_desc,
    output logic                  full,
    input  wire logic             pop,
    output ps2ev_pkg::desc_t      head_desc,
    output logic                  head_valid
);
    import ps2ev_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    desc_t            entries [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    assign full       = (cnt_reg == CNT_W'(DEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head_desc  = entries[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   cnt_next = cnt_reg + 1'b1;
            2'b01:   cnt_next = cnt_reg - 1'b1;
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
        if (push) begin
            entries[wr_ptr_reg] <= push_desc;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        full |-> !push)
        else $error("descriptor pushed into full queue");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !head_valid |-> !pop)
        else $error("descriptor popped from empty queue");

endmodule
`default_nettype wire

FILE: sv/ps2ev_back.sv
// Back end: walks each descriptor's event mask and emits one event word per cycle unless stalled.
`default_nettype none
module ps2ev_back (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire ps2ev_pkg::desc_t  head_desc,
    input  wire logic              head_valid,
    output logic                   pop,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [1:0]             m_event_type,
    output logic [8:0]             m_event_code,
    output logic signed [9:0]      m_event_value,
    output logic                   m_last_of_report
);
    import ps2ev_pkg::*;

    desc_t              cur_reg, cur_next;
    logic [EV_NUM-1:0]  pend_reg, pend_next;
    logic               m_valid_reg, m_valid_next;
    logic [1:0]         type_reg, type_next;
    logic [8:0]         code_reg, code_next;
    logic signed [9:0]  value_reg, value_next;
    logic               last_reg, last_next;

    logic               out_free;
    logic               emit;
    logic [EV_NUM-1:0]  low_bit;
    logic [EV_NUM-1:0]  pend_after;
    logic [2:0]         ev_idx;

    assign out_free   = !m_valid_reg || m_ready;
    assign emit       = out_free && (pend_reg != '0);
    assign low_bit    = pend_reg & (~pend_reg + 1'b1);
    assign pend_after = emit ? (pend_reg & ~low_bit) : pend_reg;
    // next report loads as soon as the current one has no events left
    assign pop        = (pend_after == '0) && head_valid;

    always_comb begin
        ev_idx = EVB_SYNC;
        for (int i = EV_NUM - 1; i >= 0; i--) begin
            if (low_bit[i]) begin
                ev_idx = 3'(i);
            end
        end
    end

    always_comb begin
        cur_next     = pop ? head_desc : cur_reg;
        pend_next    = pop ? head_desc.events : pend_after;
        m_valid_next = emit ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
        type_next    = type_reg;
        code_next    = code_reg;
        value_next   = value_reg;
        last_next    = last_reg;
        if (emit) begin
            last_next = 1'b0;
            case (ev_idx)
                EVB_X: begin
                    type_next  = EVT_REL;
                    code_next  = CODE_REL_X;
                    value_next = cur_reg.dx;
                end
                EVB_Y: begin
                    type_next  = EVT_REL;
                    code_next  = CODE_REL_Y;
                    value_next = cur_reg.dy;
                end
                EVB_BTN_L: begin
                    type_next  = EVT_KEY;
                    code_next  = CODE_BTN_L;
                    value_next = {9'd0, cur_reg.btn_new[0]};
                end
                EVB_BTN_R: begin
                    type_next  = EVT_KEY;
                    code_next  = CODE_BTN_R;
                    value_next = {9'd0, cur_reg.btn_new[1]};
                end
                EVB_BTN_M: begin
                    type_next  = EVT_KEY;
                    code_next  = CODE_BTN_M;
                    value_next = {9'd0, cur_reg.btn_new[2]};
                end
                EVB_KEY: begin
                    type_next  = EVT_KEY;
                    code_next  = {2'd0, cur_reg.key_code};
                    value_next = {9'd0, cur_reg.key_press};
                end
                default: begin
                    type_next  = EVT_SYNC;
                    code_next  = CODE_SYNC;
                    value_next = '0;
                    last_next  = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
        cur_reg   <= cur_next;
        type_reg  <= type_next;
        code_reg  <= code_next;
        value_reg <= value_next;
        last_reg  <= last_next;
    end

    assign m_valid          = m_valid_reg;
    assign m_event_type     = type_reg;
    assign m_event_code     = code_reg;
    assign m_event_value    = value_reg;
    assign m_last_of_report = last_reg;

    a_last_is_sync: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (last_reg == (type_reg == EVT_SYNC)))
        else $error("last_of_report does not match sync event");

    a_stall_no_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |-> !emit)
        else $error("event emitted over a stalled output word");

    a_pop_when_done: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> ((pend_reg & ~low_bit) == '0 || !emit) && (pend_after == '0))
        else $error("report loaded while events still pending");

endmodule
`default_nettype wire

FILE: sv/ps2_input_to_event_decoder.sv
// Top level of the PS/2 byte stream to input-event decoder.
// Takes one controller byte per cycle while the report queue has room; keyboard
// words and completed 3-byte mouse packets each become a report in the queue, and
// the back end emits that report's events one per cycle while m_ready is high, through a
// registered output word. A key report holds 2 events, a mouse report 1 to 6 (motion
// X, motion Y, up to three button changes, then sync). The sustained rate is therefore
// set by the output side at one event per cycle while m_ready is high; FIFO_DEPTH
// reports can be buffered so input bytes keep flowing while a long report drains.
// mouse_enable is written through cfg_wr_en/cfg_wr_data and resets to 0.
`default_nettype none
module ps2_input_to_event_decoder #(
    parameter int unsigned FIFO_DEPTH = 4
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         cfg_wr_en,
    input  wire logic         cfg_wr_data,
    input  wire logic         s_valid,
    output logic              s_ready,
    input  wire logic [7:0]   s_data_byte,
    input  wire logic         s_from_aux_port,
    output logic              m_valid,
    input  wire logic         m_ready,
    output logic [1:0]        m_event_type,
    output logic [8:0]        m_event_code,
    output logic signed [9:0] m_event_value,
    output logic              m_last_of_report
);
    import ps2ev_pkg::*;

    desc_t push_desc;
    desc_t head_desc;
    logic  push;
    logic  full;
    logic  pop;
    logic  head_valid;

    ps2ev_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data_byte     (s_data_byte),
        .s_from_aux_port (s_from_aux_port),
        .push            (push),
        .push_desc       (push_desc),
        .full            (full)
    );

    ps2ev_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_desc  (push_desc),
        .full       (full),
        .pop        (pop),
        .head_desc  (head_desc),
        .head_valid (head_valid)
    );

    ps2ev_back u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .head_desc        (head_desc),
        .head_valid       (head_valid),
        .pop              (pop),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_event_type     (m_event_type),
        .m_event_code     (m_event_code),
        .m_event_value    (m_event_value),
        .m_last_of_report (m_last_of_report)
    );

endmodule
`default_nettype wire

FILE: tb/sv/tb_top.sv
// Self-checking testbench for the PS/2 byte stream to input-event decoder.
`default_nettype none
module tb_top;
    import ps2ev_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 300000;
    localparam int unsigned SETTLE_CYCLES = 16;

    typedef struct packed {
        logic       aux;
        logic [7:0] data;
    } ps2_word_t;

    typedef struct packed {
        logic [1:0]        etype;
        logic [8:0]        code;
        logic signed [9:0] value;
        logic              last;
    } input_event_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              cfg_wr_en = 1'b0;
    logic              cfg_wr_data = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic [7:0]        s_data_byte = 8'h00;
    logic              s_from_aux_port = 1'b0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic [1:0]        m_event_type;
    logic [8:0]        m_event_code;
    logic signed [9:0] m_event_value;
    logic              m_last_of_report;

    ps2_word_t    pending_words[$];
    input_event_t expected_events[$];

    // decoder copy, updated on each accepted word
    logic       mouse_on = 1'b0;
    logic       ext_armed = 1'b0;
    logic [7:0] pkt_hold [2];
    logic [1:0] pkt_pos = 2'd0;
    logic [2:0] buttons_held = 3'b000;

    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned words_queued = 0;
    int unsigned fails = 0;
    int unsigned cycles = 0;
    logic        in_fire = 1'b0;

    ps2_input_to_event_decoder dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_data_byte      (s_data_byte),
        .s_from_aux_port  (s_from_aux_port),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_event_type     (m_event_type),
        .m_event_code     (m_event_code),
        .m_event_value    (m_event_value),
        .m_last_of_report (m_last_of_report)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic logic [8:0] ext_key_code(input logic [8:0] code);
        logic [8:0] mapped;
        case (code)
            9'h01C: mapped = 9'd96;
            9'h01D: mapped = 9'd97;
            9'h035: mapped = 9'd98;
            9'h038: mapped = 9'd100;
            9'h047: mapped = 9'd102;
            9'h048: mapped = 9'd103;
            9'h049: mapped = 9'd104;
            9'h04B: mapped = 9'd105;
            9'h04D: mapped = 9'd106;
            9'h04F: mapped = 9'd107;
            9'h050: mapped = 9'd108;
            9'h051: mapped = 9'd109;
            9'h052: mapped = 9'd110;
            9'h053: mapped = 9'd111;
            default: mapped = code;
        endcase
        return mapped;
    endfunction

    task automatic push_event(input logic [1:0] etype, input logic [8:0] code,
                              input logic signed [9:0] value, input logic last);
        input_event_t ev;
        ev.etype = etype;
        ev.code  = code;
        ev.value = value;
        ev.last  = last;
        expected_events.push_back(ev);
    endtask

    task automatic predict_word(input ps2_word_t w);
        logic [8:0]        code;
        logic [7:0]        flags;
        logic signed [9:0] dx;
        logic signed [9:0] dy;
        logic signed [9:0] ry;
        logic [8:0]        bcode;
        if (!w.aux) begin
            if (w.data == KBD_EXT_PREFIX) begin
                ext_armed = 1'b1;
            end else begin
                code = {2'b00, w.data[6:0]};
                if (ext_armed)
                    code = ext_key_code(code);
                push_event(EVT_KEY, code, w.data[7] ? 10'sd0 : 10'sd1, 1'b0);
                push_event(EVT_SYNC, CODE_SYNC, 10'sd0, 1'b1);
                ext_armed = 1'b0;
            end
        end else if (mouse_on) begin
            // packet start must carry the always-one flag bit, else dropped
            if (pkt_pos != 2'd0 || w.data[3]) begin
                if (pkt_pos < 2'd2) begin
                    pkt_hold[pkt_pos[0]] = w.data;
                    pkt_pos = pkt_pos + 2'd1;
                end else begin
                    pkt_pos = 2'd0;
                    flags = pkt_hold[0];
                    dx = $signed({{2{flags[4]}}, pkt_hold[1]});
                    ry = $signed({{2{flags[5]}}, w.data});
                    dy = -ry;
                    if (flags[6])
                        dx = flags[4] ? -10'sd255 : 10'sd255;
                    if (flags[7])
                        dy = flags[5] ? 10'sd255 : -10'sd255;
                    if (dx != 10'sd0)
                        push_event(EVT_REL, CODE_REL_X, dx, 1'b0);
                    if (dy != 10'sd0)
                        push_event(EVT_REL, CODE_REL_Y, dy, 1'b0);
                    for (int i = 0; i < 3; i++) begin
                        case (i)
                            0: bcode = CODE_BTN_L;
                            1: bcode = CODE_BTN_R;
                            default: bcode = CODE_BTN_M;
                        endcase
                        if (flags[i] != buttons_held[i])
                            push_event(EVT_KEY, bcode, flags[i] ? 10'sd1 : 10'sd0, 1'b0);
                    end
                    buttons_held = flags[2:0];
                    push_event(EVT_SYNC, CODE_SYNC, 10'sd0, 1'b1);
                end
            end
        end
    endtask

    // driver: inputs change on the falling edge
    always @(negedge aclk) begin : driver
        ps2_word_t w;
        if (aresetn && (!s_valid || in_fire)) begin
            if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                w = pending_words.pop_front();
                s_valid         <= 1'b1;
                s_data_byte     <= w.data;
                s_from_aux_port <= w.aux;
            end else begin
                s_valid <= 1'b0;
            end
        end
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // monitor: predict on accepted input words, check accepted events
    always @(posedge aclk) begin : monitor
        input_event_t ev;
        cycles = cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            in_fire = aresetn && s_valid && s_ready;
            if (in_fire)
                predict_word({s_from_aux_port, s_data_byte});
            if (aresetn && m_valid && m_ready) begin
                if (expected_events.size() == 0) begin
                    $error("unexpected event: type %0d code 0x%0h value %0d last %0d",
                           m_event_type, m_event_code, m_event_value, m_last_of_report);
                    fails = fails + 1;
                end else begin
                    ev = expected_events.pop_front();
                    if (m_event_type !== ev.etype) begin
                        $error("event_type: expected %0d, got %0d", ev.etype, m_event_type);
                        fails = fails + 1;
                    end
                    if (m_event_code !== ev.code) begin
                        $error("event_code: expected 0x%0h, got 0x%0h", ev.code, m_event_code);
                        fails = fails + 1;
                    end
                    if (m_event_value !== ev.value) begin
                        $error("event_value: expected %0d, got %0d", ev.value, m_event_value);
                        fails = fails + 1;
                    end
                    if (m_last_of_report !== ev.last) begin
                        $error("last_of_report: expected %0d, got %0d",
                               ev.last, m_last_of_report);
                        fails = fails + 1;
                    end
                end
            end
        end
    end

    task automatic push_word(input logic aux, input logic [7:0] data);
        ps2_word_t w;
        w.aux  = aux;
        w.data = data;
        pending_words.push_back(w);
        words_queued = words_queued + 1;
    endtask

    task automatic push_packet(input logic [7:0] flags, input logic [7:0] x,
                               input logic [7:0] y);
        push_word(1'b1, flags);
        push_word(1'b1, x);
        push_word(1'b1, y);
    endtask

    // all words taken, all events seen, then room for words that give no event
    task automatic wait_idle();
        while (pending_words.size() != 0 || s_valid || expected_events.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_mouse_enable(input logic en);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= en;
        mouse_on = en;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic queue_random_words(input int unsigned count);
        int unsigned start;
        int unsigned pick;
        logic [7:0]  flags;
        logic [7:0]  x;
        logic [7:0]  y;
        start = words_queued;
        while (words_queued - start < count) begin
            pick = $urandom_range(99);
            if (pick < 35) begin
                if ($urandom_range(2) == 0)
                    push_word(1'b0, KBD_EXT_PREFIX);
                x = ($urandom_range(1) == 0) ? 8'($urandom_range(8'h1C, 8'h53))
                                             : 8'($urandom_range(127));
                x[7] = 1'($urandom_range(1));
                push_word(1'b0, x);
            end else if (pick < 82) begin
                flags = 8'($urandom) | 8'h08;
                if ($urandom_range(99) >= 15)
                    flags[6] = 1'b0;
                if ($urandom_range(99) >= 15)
                    flags[7] = 1'b0;
                x = ($urandom_range(3) == 0) ? 8'h00 : 8'($urandom);
                y = ($urandom_range(3) == 0) ? 8'h00 : 8'($urandom);
                push_word(1'b1, flags);
                // keyboard words inside a packet must not upset framing
                if ($urandom_range(9) == 0)
                    push_word(1'b0, 8'($urandom_range(127)));
                push_word(1'b1, x);
                push_word(1'b1, y);
            end else begin
                push_word(1'($urandom_range(1)), 8'($urandom));
            end
        end
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // keyboard extremes, prefix handling; aux words ignored at reset
        push_word(1'b1, 8'h09);
        push_word(1'b0, 8'h00);
        push_word(1'b0, 8'hFF);
        push_word(1'b0, KBD_EXT_PREFIX);
        push_word(1'b0, KBD_EXT_PREFIX);
        push_word(1'b0, 8'h1C);
        push_word(1'b0, KBD_EXT_PREFIX);
        push_word(1'b0, 8'hC8);
        push_word(1'b0, KBD_EXT_PREFIX);
        push_word(1'b0, 8'h2A);
        wait_idle();

        write_mouse_enable(1'b1);
        push_word(1'b1, 8'h00);           // no sync bit: dropped
        push_packet(8'h0F, 8'hFF, 8'h00);
        push_word(1'b1, 8'h38);
        push_word(1'b0, 8'h10);
        push_word(1'b1, 8'h00);
        push_word(1'b1, 8'h00);           // both axes at -256
        push_packet(8'hF8, 8'h12, 8'h34); // both overflow, negative
        push_packet(8'h4F, 8'h00, 8'h01); // X overflow positive
        wait_idle();

        for (int ph = 0; ph < 6; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 82; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 82; end
                default: begin send_idle_pct = 29; recv_stall_pct = 29; end
            endcase
            write_mouse_enable((ph == 1 || ph == 4) ? 1'b0 : 1'b1);
            queue_random_words(45);
            wait_idle();
        end

        if (fails == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
`default_nettype wire
